/* rtl/core/particle_weight_resampler_macros.svh */
// Assertion helpers for the resampler RTL.
`ifndef PARTICLE_WEIGHT_RESAMPLER_MACROS_SVH
`define PARTICLE_WEIGHT_RESAMPLER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define PWR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the following cycle.
`define PWR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pwr_pkg.sv */
package pwr_pkg;

	localparam int LIK_W    = 32;
	localparam int IDX_W    = 6;
	localparam int WGT_W    = 32;
	localparam int CNT_W    = 7;
	localparam int THR_W    = 17;
	localparam int STORE_W  = 48;
	localparam int CUM_W    = 40;
	localparam int SUM_W    = 56;
	localparam int SQS_W    = CNT_W + WGT_W;
	localparam int CFG_IX_W = 2;
	localparam int CFG_D_W  = 32;
	localparam int OUT_D_W  = 48;

	localparam int MAX_PARTICLES_DEF = 64;

	localparam logic [31:0]    RNG_DEFAULT = 32'h9E37_79B9;
	localparam logic [THR_W-1:0] THR_HALF  = 17'd32768;
	localparam logic [THR_W-1:0] THR_ONE   = 17'd65536;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IX_W-1:0] {
		CFG_COUNT  = 2'd0,
		CFG_THRESH = 2'd1,
		CFG_SEED   = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_MUL,
		ST_UPD_WR,
		ST_FIN,
		ST_NORM_RD,
		ST_NORM_DIV,
		ST_NORM_WAIT,
		ST_NORM_WR,
		ST_ESS_RD,
		ST_ESS_MUL,
		ST_ESS_ACC,
		ST_CMP1,
		ST_CMP2,
		ST_CUM_RD,
		ST_CUM_WR,
		ST_RNG,
		ST_WALK_RD,
		ST_WALK_MUL,
		ST_WALK_CMP,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} state_t;

	// One xorshift32 step (shifts 13, 17, 5)
	function automatic logic [31:0] xorshift32(input logic [31:0] s);
		logic [31:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage

/* rtl/core/particle_weight_resampler.sv */
// Particle weight update and systematic resampler. One likelihood (signed Q16.16 on
// s_axis_tdata, negatives read as zero) is taken per particle in particle order; each
// passes through the weight memory read, the 32x32 multiply and the write-back.
// No result leaves until the last particle's likelihood is in. The final item then runs
// passes over the weight memory: normalization through a shared bit-serial divider
// (the weight saturates when it is not below the sum; skipped when the sum is zero), an
// effective-N pass, and, when resampling, a cumulative-sum pass and an ancestor walk
// (at most 2N steps). One result per particle follows, each held until taken. Writing
// particle_count starts the divider on the uniform weight, which holds off input until
// the division is done.
`include "particle_weight_resampler_macros.svh"

module particle_weight_resampler
	import pwr_pkg::*;
#(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [CFG_D_W-1:0]  cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [LIK_W-1:0]    s_axis_tdata,  // [31:0] likelihood
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [5:0] particle_index, [11:6] ancestor_index, [43:12] weight,
	// [44] resampled, [45] collapsed, [47:46] zero
	output logic [OUT_D_W-1:0]  m_axis_tdata,
	output logic                m_axis_tlast
);

	localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_PARTICLES);
	localparam logic [32:0] UNI_RST = 33'h1_0000_0000 / MAX_PARTICLES;

	state_t state_q, state_d;

	logic [CNT_W-1:0]   count_q;
	logic [THR_W-1:0]   thresh_q;
	logic [31:0]        rng_q;
	logic [CNT_W-1:0]   ctr_q;
	logic [SUM_W-1:0]   sum_q;
	logic [WGT_W-1:0]   uni_q;
	logic [MAX_PARTICLES-1:0] vld_q;
	logic [LIK_W-2:0]   lik_q;
	logic [63:0]        prod_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   j_q;
	logic [SQS_W-1:0]   s_q;
	logic [SQS_W+CNT_W-1:0] m1_q;
	logic               res_q;
	logic               col_q;
	logic [CUM_W-1:0]   acc_q;
	logic [31:0]        x_q;
	logic [CUM_W+CNT_W-1:0] cm_q;

	// Divider
	logic               div_busy_q;
	logic               div_uni_q;
	logic [SUM_W-1:0]   div_r_q;
	logic [SUM_W-1:0]   div_den_q;
	logic [WGT_W-1:0]   div_quo_q;
	logic [5:0]         div_cnt_q;
	logic               div_start;
	logic               div_uni;
	logic [SUM_W-1:0]   div_num;
	logic [SUM_W-1:0]   div_den;
	logic [SUM_W:0]     div_r2;
	logic               div_ge;

	// Output register
	logic               ov_q;
	logic [IDX_W-1:0]   opi_q;
	logic [IDX_W-1:0]   oanc_q;
	logic [WGT_W-1:0]   ow_q;
	logic               ores_q;
	logic               ocol_q;
	logic               olast_q;

	// Memories
	logic [STORE_W-1:0] wmem [MAX_PARTICLES];
	logic [CUM_W-1:0]   cmem [MAX_PARTICLES];
	logic [STORE_W-1:0] w_rdata;
	logic               w_rvld_s1;
	logic [CUM_W-1:0]   c_rdata;
	logic [AW-1:0]      w_raddr;
	logic               w_we;
	logic [AW-1:0]      w_waddr;
	logic [STORE_W-1:0] w_wdata;
	logic [AW-1:0]      c_raddr;
	logic               c_we;
	logic [CUM_W-1:0]   c_wdata;

	logic [STORE_W-1:0] w_rd;
	logic [WGT_W-1:0]   w_lo;
	logic [CNT_W-1:0]   k_next;
	logic               k_more;
	logic [STORE_W-1:0] p48;
	logic [CUM_W-1:0]   acc_next;
	logic [THR_W-1:0]   t_eff;
	logic [SQS_W+CNT_W+THR_W-1:0] m2;
	logic [CUM_W-1:0]   u_val;
	logic               walk_adv;
	logic               out_fire;
	logic               in_fire;
	logic [CNT_W-1:0]   cfg_n;
	logic [31:0]        x_new;

	// Read data of an entry never written since the last fill is the uniform weight
	assign w_rd     = w_rvld_s1 ? w_rdata : STORE_W'(uni_q);
	assign w_lo     = w_rd[WGT_W-1:0];
	assign k_next   = k_q + CNT_W'(1);
	assign k_more   = k_next < count_q;
	assign p48      = prod_q[STORE_W+15:16];
	assign acc_next = acc_q + CUM_W'(w_lo);
	assign t_eff    = (thresh_q == '0 || thresh_q > THR_ONE) ? THR_HALF : thresh_q;
	assign m2       = m1_q * t_eff;
	assign u_val    = {1'b0, k_q, x_q};
	assign walk_adv = (j_q + CNT_W'(1) < count_q) && ((CUM_W+CNT_W)'(u_val) > cm_q);
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign x_new    = xorshift32(rng_q);

	always_comb begin
		cfg_n = cfg_data[CNT_W-1:0];
		if (cfg_n == '0) begin
			cfg_n = CNT_W'(1);
		end else if (cfg_n > MAX_N) begin
			cfg_n = MAX_N;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !div_busy_q;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {2'b00, ocol_q, ores_q, ow_q, oanc_q, opi_q};
	assign m_axis_tlast  = olast_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_fire) state_d = ST_UPD_RD;
			ST_UPD_RD:    state_d = ST_UPD_MUL;
			ST_UPD_MUL:   state_d = ST_UPD_WR;
			ST_UPD_WR:    state_d = (ctr_q + CNT_W'(1) < count_q) ? ST_IDLE : ST_FIN;
			ST_FIN:       state_d = (sum_q == '0) ? ST_ESS_RD : ST_NORM_RD;
			ST_NORM_RD:   state_d = ST_NORM_DIV;
			ST_NORM_DIV:  state_d = ST_NORM_WAIT;
			ST_NORM_WAIT: if (!div_busy_q) state_d = ST_NORM_WR;
			ST_NORM_WR:   state_d = k_more ? ST_NORM_RD : ST_ESS_RD;
			ST_ESS_RD:    state_d = ST_ESS_MUL;
			ST_ESS_MUL:   state_d = ST_ESS_ACC;
			ST_ESS_ACC:   state_d = k_more ? ST_ESS_RD : ST_CMP1;
			ST_CMP1:      state_d = ST_CMP2;
			ST_CMP2:      state_d = (m2 > 63'h1_0000_0000_0000) ? ST_CUM_RD : ST_OUT_RD;
			ST_CUM_RD:    state_d = ST_CUM_WR;
			ST_CUM_WR:    state_d = k_more ? ST_CUM_RD : ST_RNG;
			ST_RNG:       state_d = ST_WALK_RD;
			ST_WALK_RD:   state_d = ST_WALK_MUL;
			ST_WALK_MUL:  state_d = ST_WALK_CMP;
			ST_WALK_CMP:  state_d = walk_adv ? ST_WALK_RD : ST_OUT_WAIT;
			ST_OUT_RD:    state_d = ST_OUT_LD;
			ST_OUT_LD:    state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: begin
				if (out_fire) begin
					if (olast_q) begin
						state_d = ST_IDLE;
					end else begin
						state_d = res_q ? ST_WALK_RD : ST_OUT_RD;
					end
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Memory ports and divider start
	always_comb begin
		w_raddr   = k_q[AW-1:0];
		w_we      = 1'b0;
		w_waddr   = k_q[AW-1:0];
		w_wdata   = p48;
		c_raddr   = j_q[AW-1:0];
		c_we      = 1'b0;
		c_wdata   = acc_next;
		div_start = 1'b0;
		div_uni   = 1'b0;
		div_num   = SUM_W'(w_rd);
		div_den   = sum_q;
		case (state_q)
			ST_UPD_RD: begin
				w_raddr = ctr_q[AW-1:0];
			end
			ST_UPD_WR: begin
				w_we    = 1'b1;
				w_waddr = ctr_q[AW-1:0];
			end
			ST_NORM_DIV: begin
				div_start = 1'b1;
			end
			ST_NORM_WR: begin
				w_we    = 1'b1;
				w_wdata = STORE_W'(div_quo_q);
			end
			ST_CUM_WR: begin
				c_we = 1'b1;
			end
			ST_IDLE: begin
				if (cfg_we && cfg_index == CFG_COUNT) begin
					div_start = 1'b1;
					div_uni   = 1'b1;
					div_num   = SUM_W'(1);
					div_den   = SUM_W'(cfg_n);
				end
			end
			default: begin
			end
		endcase
	end

	// Weight and cumulative memories
	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_waddr] <= w_wdata;
		end
		w_rdata <= wmem[w_raddr];
		if (c_we) begin
			cmem[k_q[AW-1:0]] <= c_wdata;
		end
		c_rdata <= cmem[c_raddr];
	end

	// Restoring divider, one quotient bit a cycle
	assign div_r2 = {div_r_q, 1'b0};
	assign div_ge = div_r2 >= {1'b0, div_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_uni_q  <= 1'b0;
			div_cnt_q  <= '0;
			uni_q      <= UNI_RST[WGT_W-1:0];
		end else if (div_start) begin
			div_busy_q <= 1'b1;
			div_uni_q  <= div_uni;
			div_cnt_q  <= (div_num >= div_den) ? 6'd0 : 6'd32;
		end else if (div_busy_q) begin
			if (div_cnt_q == '0) begin
				div_busy_q <= 1'b0;
				if (div_uni_q) begin
					uni_q <= div_quo_q;
				end
			end else begin
				div_cnt_q <= div_cnt_q - 6'd1;
			end
		end
	end

	// The remainder stays below the divisor, so it fits the divisor width
	always_ff @(posedge clk) begin
		if (div_start) begin
			div_r_q   <= div_num;
			div_den_q <= div_den;
			div_quo_q <= (div_num >= div_den) ? '1 : '0;
		end else if (div_busy_q && div_cnt_q != '0) begin
			div_r_q   <= div_ge ? SUM_W'(div_r2 - {1'b0, div_den_q}) : div_r2[SUM_W-1:0];
			div_quo_q <= {div_quo_q[WGT_W-2:0], div_ge};
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= MAX_N;
			thresh_q  <= THR_HALF;
			rng_q     <= RNG_DEFAULT;
			ctr_q     <= '0;
			sum_q     <= '0;
			vld_q     <= '0;
			w_rvld_s1 <= 1'b0;
			k_q       <= '0;
			j_q       <= '0;
			res_q     <= 1'b0;
			col_q     <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			w_rvld_s1 <= vld_q[w_raddr];
			if (w_we) begin
				vld_q[w_waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						case (cfg_index)
							CFG_COUNT: begin
								count_q <= cfg_n;
								ctr_q   <= '0;
								sum_q   <= '0;
								vld_q   <= '0;
							end
							CFG_THRESH: thresh_q <= cfg_data[THR_W-1:0];
							CFG_SEED:   rng_q <= (cfg_data == '0) ? RNG_DEFAULT : cfg_data;
							default: begin
							end
						endcase
					end
				end
				ST_UPD_WR: begin
					sum_q <= sum_q + SUM_W'(p48);
					ctr_q <= (ctr_q + CNT_W'(1) < count_q) ? ctr_q + CNT_W'(1) : '0;
				end
				ST_FIN: begin
					k_q   <= '0;
					col_q <= (sum_q == '0);
					if (sum_q == '0) begin
						vld_q <= '0;
					end
				end
				ST_NORM_WR: k_q <= k_more ? k_next : '0;
				ST_ESS_ACC: k_q <= k_more ? k_next : '0;
				ST_CMP2: begin
					res_q <= (m2 > 63'h1_0000_0000_0000);
					k_q   <= '0;
				end
				ST_CUM_WR: k_q <= k_more ? k_next : '0;
				ST_RNG: begin
					rng_q <= x_new;
					k_q   <= '0;
					j_q   <= '0;
				end
				ST_WALK_CMP: begin
					if (walk_adv) begin
						j_q <= j_q + CNT_W'(1);
					end else begin
						ov_q <= 1'b1;
					end
				end
				ST_OUT_LD: ov_q <= 1'b1;
				ST_OUT_WAIT: begin
					if (out_fire) begin
						ov_q <= 1'b0;
						if (olast_q) begin
							k_q   <= '0;
							sum_q <= '0;
							if (res_q) begin
								vld_q <= '0;
							end
						end else begin
							k_q <= k_next;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			lik_q <= s_axis_tdata[LIK_W-1] ? '0 : s_axis_tdata[LIK_W-2:0];
		end
		case (state_q)
			ST_UPD_MUL: prod_q <= w_lo * {1'b0, lik_q};
			ST_FIN:     s_q <= '0;
			ST_ESS_MUL: prod_q <= w_lo * w_lo;
			ST_ESS_ACC: s_q <= s_q + SQS_W'(prod_q[63:32]);
			ST_CMP1: begin
				m1_q  <= s_q * count_q;
				acc_q <= '0;
			end
			ST_CUM_WR:  acc_q <= acc_next;
			ST_RNG:     x_q <= x_new;
			ST_WALK_MUL: cm_q <= c_rdata * count_q;
			ST_WALK_CMP: begin
				opi_q   <= k_q[IDX_W-1:0];
				oanc_q  <= j_q[IDX_W-1:0];
				ow_q    <= uni_q;
				ores_q  <= 1'b1;
				ocol_q  <= col_q;
				olast_q <= (k_next == count_q);
			end
			ST_OUT_LD: begin
				opi_q   <= k_q[IDX_W-1:0];
				oanc_q  <= k_q[IDX_W-1:0];
				ow_q    <= w_lo;
				ores_q  <= 1'b0;
				ocol_q  <= col_q;
				olast_q <= (k_next == count_q);
			end
			default: begin
			end
		endcase
	end

	`PWR_ASSERT_NOW(a_no_input_while_result, s_axis_tready, !m_axis_tvalid, "input taken while result pending")
	`PWR_ASSERT_NOW(a_div_blocks_input, div_busy_q, !s_axis_tready, "input taken during division")
	`PWR_ASSERT_NEXT(a_last_ends_run, out_fire && m_axis_tlast, state_q == ST_IDLE && ctr_q == '0, "run did not end after last result")
	`PWR_ASSERT_NOW(a_walk_in_range, state_q == ST_WALK_CMP || state_q == ST_WALK_MUL, j_q < count_q, "ancestor beyond particle count")

endmodule
